@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/etsl_pkg.sv @@
// ----------------------------------------------------------------------------
// etsl_pkg
// Shared widths, codes, sort key and control types of the SCAN target list.
// ----------------------------------------------------------------------------
package etsl_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int OP_W    = 2;
   localparam int FLOOR_W = 6;
   localparam int DIR_W   = 2;
   localparam int COUNT_W = 5;
   localparam int KEY_W   = FLOOR_W + 1;

   localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
   localparam logic [OP_W-1:0] OP_REORDER = 2'd2;

   localparam logic [DIR_W-1:0] DIR_HERE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

   typedef struct packed {
      logic clear;
      logic step;
   } rank_ctrl_type;

   // First group gets keys with MSB clear, second group MSB set, so an
   // ascending key order is the SCAN order.
   function automatic logic [KEY_W-1:0] scan_key(
      input logic [FLOOR_W-1:0] floor_val,
      input logic [FLOOR_W-1:0] cur,
      input logic [DIR_W-1:0]   dir
   );
      logic [KEY_W-1:0] key;
      if (dir == DIR_UP) begin
         key = (floor_val > cur) ? {1'b0, floor_val} : {1'b1, ~floor_val};
      end else begin
         key = (floor_val < cur) ? {1'b0, ~floor_val} : {1'b1, floor_val};
      end
      return key;
   endfunction

endpackage

@@ sv/etsl_if.sv @@
// ----------------------------------------------------------------------------
// etsl_req_if / etsl_rsp_if
// Valid/ready channels for requests and status responses.
// ----------------------------------------------------------------------------
interface etsl_req_if;
   logic                          valid;
   logic                          ready;
   logic [etsl_pkg::OP_W-1:0]     operation;
   logic [etsl_pkg::FLOOR_W-1:0]  target_floor;
   logic [etsl_pkg::FLOOR_W-1:0]  current_floor;
   logic [etsl_pkg::DIR_W-1:0]    travel_direction;

   modport source (output valid, operation, target_floor, current_floor,
                   travel_direction, input ready);
   modport sink   (input valid, operation, target_floor, current_floor,
                   travel_direction, output ready);
endinterface

interface etsl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [etsl_pkg::FLOOR_W-1:0]  head_floor;
   logic [etsl_pkg::COUNT_W-1:0]  pending_count;
   logic [etsl_pkg::DIR_W-1:0]    head_direction;
   logic                          list_empty;
   logic                          rejected;

   modport source (output valid, head_floor, pending_count, head_direction,
                   list_empty, rejected, input ready);
   modport sink   (input valid, head_floor, pending_count, head_direction,
                   list_empty, rejected, output ready);
endinterface

@@ sv/etsl_mem.sv @@
// ----------------------------------------------------------------------------
// etsl_mem
// Floor storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module etsl_mem #(
   parameter int ADDR_W = 5,
   parameter int DATA_W = etsl_pkg::FLOOR_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [DATA_W-1:0] rd_a_data,
   output logic [DATA_W-1:0] rd_b_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

@@ sv/etsl_rank_unit.sv @@
// ----------------------------------------------------------------------------
// etsl_rank_unit
// Shared key compare and rank counter: counts entries that sort ahead of
// the entry under test (stable on equal keys).
// ----------------------------------------------------------------------------
module etsl_rank_unit #(
   parameter int CNT_W = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  etsl_pkg::rank_ctrl_type       ctrl,
   input  logic [etsl_pkg::FLOOR_W-1:0]  floor_a,
   input  logic [etsl_pkg::FLOOR_W-1:0]  floor_b,
   input  logic [CNT_W-1:0]              idx_a,
   input  logic [CNT_W-1:0]              idx_b,
   input  logic [etsl_pkg::FLOOR_W-1:0]  cur,
   input  logic [etsl_pkg::DIR_W-1:0]    dir,
   output logic [CNT_W-1:0]              rank
);

   logic [etsl_pkg::KEY_W-1:0] key_a;
   logic [etsl_pkg::KEY_W-1:0] key_b;
   logic                       ahead;
   logic [CNT_W-1:0]           rank_ff;
   logic [CNT_W-1:0]           rank_in;

   always_comb begin
      key_a = etsl_pkg::scan_key(floor_a, cur, dir);
      key_b = etsl_pkg::scan_key(floor_b, cur, dir);
      ahead = (key_b < key_a) || ((key_b == key_a) && (idx_b < idx_a));
      if (ctrl.clear) begin
         rank_in = '0;
      end else if (ctrl.step && ahead) begin
         rank_in = rank_ff + CNT_W'(1);
      end else begin
         rank_in = rank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
      end else begin
         rank_ff <= rank_in;
      end
   end

   assign rank = rank_ff;

endmodule

@@ sv/elevator_scan_target_list.sv @@
// ----------------------------------------------------------------------------
// elevator_scan_target_list
// Bounded list of target floors with append, remove head and SCAN reorder.
//
//   channel   dir   handshake            contents
//   req_ch    in    valid/ready          operation, floors, travel direction
//   rsp_ch    out   valid/ready          head floor, count, direction, flags
//
// Append, remove and no-op requests pass through the execute, read and done
// states; done holds while an earlier response still waits on rsp_ch.
// Reorder of n entries (up or down, n > 1) adds a scan: one rank compare unit
// scans all n entries for each entry, then writes it to the other bank.
// req_ch.ready is high only while idle; the response register lets the next
// request in while a response is still waiting. Reset empties the list.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elevator_scan_target_list #(
   parameter int CAPACITY = etsl_pkg::CAPACITY_DEF
) (
   input  logic          clock,
   input  logic          reset,
   etsl_req_if.sink      req_ch,
   etsl_rsp_if.source    rsp_ch
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int ADDR_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [etsl_pkg::OP_W-1:0]     op_ff, op_in;
   logic [etsl_pkg::FLOOR_W-1:0]  tgt_ff, tgt_in;
   logic [etsl_pkg::FLOOR_W-1:0]  cur_ff, cur_in;
   logic [etsl_pkg::DIR_W-1:0]    dir_ff, dir_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic                          bank_ff, bank_in;
   logic                          rej_ff, rej_in;
   logic [CNT_W-1:0]              i_ff, i_in;
   logic [CNT_W-1:0]              j_ff, j_in;
   logic [CNT_W-1:0]              jd_ff, jd_in;
   logic                          jv_ff, jv_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [etsl_pkg::FLOOR_W-1:0]  rsp_head_ff, rsp_head_in;
   logic [etsl_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [etsl_pkg::DIR_W-1:0]    rsp_dir_ff, rsp_dir_in;
   logic                          rsp_empty_ff, rsp_empty_in;
   logic                          rsp_rej_ff, rsp_rej_in;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [etsl_pkg::FLOOR_W-1:0]  wr_data;
   logic [ADDR_W-1:0]             rd_a_addr;
   logic [ADDR_W-1:0]             rd_b_addr;
   logic [etsl_pkg::FLOOR_W-1:0]  rd_a_data;
   logic [etsl_pkg::FLOOR_W-1:0]  rd_b_data;

   etsl_pkg::rank_ctrl_type       rank_ctrl;
   logic [CNT_W-1:0]              rank;

   logic                          req_fire;
   logic                          list_empty;
   logic [etsl_pkg::FLOOR_W-1:0]  head_val;

   // Logical position to physical slot of the ring.
   function automatic logic [IDX_W-1:0] wrap_idx(
      input logic [IDX_W-1:0] base,
      input logic [CNT_W-1:0] ofs
   );
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(ofs);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   etsl_mem #(
      .ADDR_W (ADDR_W),
      .DATA_W (etsl_pkg::FLOOR_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   etsl_rank_unit #(
      .CNT_W (CNT_W)
   ) u_rank (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (rank_ctrl),
      .floor_a (rd_a_data),
      .floor_b (rd_b_data),
      .idx_a   (i_ff),
      .idx_b   (jd_ff),
      .cur     (cur_ff),
      .dir     (dir_ff),
      .rank    (rank)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rd_a_addr = (state_ff == ST_SCAN) ? {bank_ff, wrap_idx(head_ff, i_ff)}
                                            : {bank_ff, head_ff};
   assign rd_b_addr = {bank_ff, wrap_idx(head_ff, j_ff)};

   assign list_empty = (count_ff == '0);
   assign head_val   = list_empty ? '0 : rd_a_data;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tgt_in       = tgt_ff;
      cur_in       = cur_ff;
      dir_in       = dir_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      bank_in      = bank_ff;
      rej_in       = rej_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jd_in        = jd_ff;
      jv_in        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = {bank_ff, wrap_idx(head_ff, count_ff)};
      wr_data      = tgt_ff;
      rank_ctrl    = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_head_in  = rsp_head_ff;
      rsp_count_in = rsp_count_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_rej_in   = rsp_rej_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_ch.operation;
               tgt_in   = req_ch.target_floor;
               cur_in   = req_ch.current_floor;
               dir_in   = req_ch.travel_direction;
               rej_in   = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_READ;
            case (op_ff)
               etsl_pkg::OP_APPEND: begin
                  if (count_ff == CAP_CNT) begin
                     rej_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               etsl_pkg::OP_REMOVE: begin
                  if (list_empty) begin
                     rej_in = 1'b1;
                  end else begin
                     head_in  = wrap_idx(head_ff, CNT_W'(1));
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               etsl_pkg::OP_REORDER: begin
                  if ((dir_ff == etsl_pkg::DIR_UP || dir_ff == etsl_pkg::DIR_DOWN) &&
                      count_ff > CNT_W'(1)) begin
                     i_in            = '0;
                     j_in            = '0;
                     rank_ctrl.clear = 1'b1;
                     state_in        = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            rank_ctrl.step = jv_ff;
            if (j_ff != count_ff) begin
               j_in  = j_ff + CNT_W'(1);
               jd_in = j_ff;
               jv_in = 1'b1;
            end else if (!jv_ff) begin
               // rank is final: place entry i in the other bank
               wr_en           = 1'b1;
               wr_addr         = {~bank_ff, rank[IDX_W-1:0]};
               wr_data         = rd_a_data;
               rank_ctrl.clear = 1'b1;
               if (i_ff == count_ff - CNT_W'(1)) begin
                  bank_in  = ~bank_ff;
                  head_in  = '0;
                  state_in = ST_READ;
               end else begin
                  i_in = i_ff + CNT_W'(1);
                  j_in = '0;
               end
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = head_val;
               rsp_count_in = etsl_pkg::COUNT_W'(count_ff);
               rsp_empty_in = list_empty;
               rsp_rej_in   = rej_ff;
               if (list_empty || head_val == cur_ff) begin
                  rsp_dir_in = etsl_pkg::DIR_HERE;
               end else if (head_val > cur_ff) begin
                  rsp_dir_in = etsl_pkg::DIR_UP;
               end else begin
                  rsp_dir_in = etsl_pkg::DIR_DOWN;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         bank_ff      <= 1'b0;
         rej_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         jv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         bank_ff      <= bank_in;
         rej_ff       <= rej_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         jv_ff        <= jv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tgt_ff       <= tgt_in;
      cur_ff       <= cur_in;
      dir_ff       <= dir_in;
      jd_ff        <= jd_in;
      rsp_head_ff  <= rsp_head_in;
      rsp_count_ff <= rsp_count_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.head_floor     = rsp_head_ff;
   assign rsp_ch.pending_count  = rsp_count_ff;
   assign rsp_ch.head_direction = rsp_dir_ff;
   assign rsp_ch.list_empty     = rsp_empty_ff;
   assign rsp_ch.rejected       = rsp_rej_ff;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CAP_CNT, "entry count above capacity")
   `ASSERT_NEXT(a_busy_after_accept, req_fire, !req_ch.ready, "ready right after accept")
   `ASSERT_ALWAYS(a_empty_status,
      !(rsp_ch.valid && rsp_ch.list_empty) ||
      (rsp_ch.head_floor == '0 && rsp_ch.head_direction == etsl_pkg::DIR_HERE),
      "empty list reports a head")
   `ASSERT_ALWAYS(a_rank_bound, state_ff != ST_SCAN || rank < count_ff, "rank out of range")

endmodule

@@ verif/scan_list_checker.sv @@
// ----------------------------------------------------------------------------
// scan_list_checker
// Watches the request and response channels of the SCAN target list. It keeps
// its own copy of the floor list, predicts the status of every accepted
// request, and compares each accepted response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scan_list_checker #(
   parameter int CAPACITY = etsl_pkg::CAPACITY_DEF
) (
   input  logic  clock,
   input  logic  reset,
   etsl_req_if   req_ch,
   etsl_rsp_if   rsp_ch,
   output int    mismatches,
   output int    awaited,
   output int    checked,
   output int    rejects
);

   localparam int TOP_FLOOR = (1 << etsl_pkg::FLOOR_W) - 1;

   typedef struct packed {
      logic [etsl_pkg::FLOOR_W-1:0] head_floor;
      logic [etsl_pkg::COUNT_W-1:0] pending_count;
      logic [etsl_pkg::DIR_W-1:0]   head_direction;
      logic                         list_empty;
      logic                         rejected;
   } list_status_type;

   logic [etsl_pkg::FLOOR_W-1:0] floors_q [CAPACITY];
   int                           held;
   int                           err_cnt;
   int                           rsp_cnt;
   int                           rej_cnt;
   list_status_type              status_q [$];

   // Sweep order: walk the floors in the order the car would pass them and
   // pick up every held entry on the way.
   function automatic void sort_for_sweep(input logic [etsl_pkg::FLOOR_W-1:0] cur,
                                          input logic [etsl_pkg::DIR_W-1:0]   dir);
      logic [etsl_pkg::FLOOR_W-1:0] visit [TOP_FLOOR+1];
      logic [etsl_pkg::FLOOR_W-1:0] sorted [CAPACITY];
      int                           k;
      int                           n;
      int                           v;
      int                           i;
      k = 0;
      if (dir == etsl_pkg::DIR_UP) begin
         for (v = int'(cur) + 1; v <= TOP_FLOOR; v++) begin
            visit[k] = etsl_pkg::FLOOR_W'(v);
            k++;
         end
         for (v = int'(cur); v >= 0; v--) begin
            visit[k] = etsl_pkg::FLOOR_W'(v);
            k++;
         end
      end else if (dir == etsl_pkg::DIR_DOWN) begin
         for (v = int'(cur) - 1; v >= 0; v--) begin
            visit[k] = etsl_pkg::FLOOR_W'(v);
            k++;
         end
         for (v = int'(cur); v <= TOP_FLOOR; v++) begin
            visit[k] = etsl_pkg::FLOOR_W'(v);
            k++;
         end
      end else begin
         return;
      end
      n = 0;
      for (k = 0; k <= TOP_FLOOR; k++) begin
         for (i = 0; i < held; i++) begin
            if (floors_q[i] == visit[k]) begin
               sorted[n] = visit[k];
               n++;
            end
         end
      end
      for (i = 0; i < held; i++) begin
         floors_q[i] = sorted[i];
      end
   endfunction

   function automatic list_status_type advance_list(
      input logic [etsl_pkg::OP_W-1:0]    op,
      input logic [etsl_pkg::FLOOR_W-1:0] tgt,
      input logic [etsl_pkg::FLOOR_W-1:0] cur,
      input logic [etsl_pkg::DIR_W-1:0]   dir
   );
      list_status_type st;
      int              i;
      st = '0;
      case (op)
         etsl_pkg::OP_APPEND: begin
            if (held >= CAPACITY) begin
               st.rejected = 1'b1;
            end else begin
               floors_q[held] = tgt;
               held++;
            end
         end
         etsl_pkg::OP_REMOVE: begin
            if (held == 0) begin
               st.rejected = 1'b1;
            end else begin
               for (i = 0; i + 1 < held; i++) begin
                  floors_q[i] = floors_q[i+1];
               end
               held--;
            end
         end
         etsl_pkg::OP_REORDER: begin
            sort_for_sweep(cur, dir);
         end
         default: begin
         end
      endcase
      st.pending_count  = etsl_pkg::COUNT_W'(held);
      st.list_empty     = (held == 0);
      st.head_direction = etsl_pkg::DIR_HERE;
      if (held > 0) begin
         st.head_floor = floors_q[0];
         if (floors_q[0] > cur) begin
            st.head_direction = etsl_pkg::DIR_UP;
         end else if (floors_q[0] < cur) begin
            st.head_direction = etsl_pkg::DIR_DOWN;
         end
      end
      return st;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH on response %0d: %s", $time, rsp_cnt, msg);
      err_cnt++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      list_status_type want;
      if (reset) begin
         held = 0;
         status_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (status_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = status_q.pop_front();
               check_field("head_floor", rsp_ch.head_floor, want.head_floor);
               check_field("pending_count", rsp_ch.pending_count, want.pending_count);
               check_field("head_direction", rsp_ch.head_direction, want.head_direction);
               check_field("list_empty", rsp_ch.list_empty, want.list_empty);
               check_field("rejected", rsp_ch.rejected, want.rejected);
            end
            rsp_cnt++;
         end
         if (req_ch.valid && req_ch.ready) begin
            want = advance_list(req_ch.operation, req_ch.target_floor,
                                req_ch.current_floor, req_ch.travel_direction);
            if (want.rejected) begin
               rej_cnt++;
            end
            status_q.push_back(want);
         end
      end
      mismatches <= err_cnt;
      awaited    <= status_q.size();
      checked    <= rsp_cnt;
      rejects    <= rej_cnt;
   end

endmodule

@@ verif/elevator_scan_target_list_tb.sv @@
// ----------------------------------------------------------------------------
// elevator_scan_target_list_tb
// Drives directed and random append / remove / reorder / no-op transactions into the
// SCAN target list under varying sender and receiver idling; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module elevator_scan_target_list_tb;

   localparam logic [etsl_pkg::OP_W-1:0]  OP_NONE  = 2'd3;
   localparam logic [etsl_pkg::DIR_W-1:0] DIR_NONE = 2'd3;

   localparam int PHASE_ITEMS = 350;
   localparam int MODE_SPAN   = 48;
   localparam int CYCLE_LIMIT = 1_500_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 30;
   int rsp_stall_pct = 47;
   int cycles;
   int op_seen [4];

   int mismatches;
   int awaited;
   int checked;
   int rejects;

   etsl_req_if req_ch();
   etsl_rsp_if rsp_ch();

   elevator_scan_target_list i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   scan_list_checker i_chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .mismatches (mismatches),
      .awaited    (awaited),
      .checked    (checked),
      .rejects    (rejects)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding", cycles, awaited);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response backpressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_request(input logic [etsl_pkg::OP_W-1:0]    op,
                               input logic [etsl_pkg::FLOOR_W-1:0] tgt,
                               input logic [etsl_pkg::FLOOR_W-1:0] cur,
                               input logic [etsl_pkg::DIR_W-1:0]   dir);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.operation        <= op;
      req_ch.target_floor     <= tgt;
      req_ch.current_floor    <= cur;
      req_ch.travel_direction <= dir;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      op_seen[op]++;
   endtask

   // Hold off until every outstanding transaction has been answered.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (awaited != 0);
   endtask

   // Bias toward the floor extremes so duplicates and head == current occur.
   function automatic logic [etsl_pkg::FLOOR_W-1:0] pick_floor();
      if ($urandom_range(9) < 3) begin
         return $urandom_range(1) ? etsl_pkg::FLOOR_W'($urandom_range(3))
                                  : etsl_pkg::FLOOR_W'(60 + $urandom_range(3));
      end
      return etsl_pkg::FLOOR_W'($urandom_range(63));
   endfunction

   initial begin
      logic [etsl_pkg::FLOOR_W-1:0] fill_floors [16];
      logic [etsl_pkg::OP_W-1:0]    op;
      logic [etsl_pkg::DIR_W-1:0]   dir;
      logic                         filling;
      int                           phase;
      int                           n;
      int                           r;

      fill_floors = '{6'd63, 6'd0, 6'd17, 6'd40, 6'd5, 6'd63, 6'd33, 6'd12,
                      6'd50, 6'd0, 6'd28, 6'd45, 6'd7, 6'd31, 6'd60, 6'd21};
      req_ch.valid            <= 1'b0;
      req_ch.operation        <= etsl_pkg::OP_APPEND;
      req_ch.target_floor     <= '0;
      req_ch.current_floor    <= '0;
      req_ch.travel_direction <= etsl_pkg::DIR_HERE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list corner cases, fill to capacity, overflow, sweeps
      send_request(etsl_pkg::OP_REMOVE, 6'd9, 6'd0, etsl_pkg::DIR_HERE);
      send_request(etsl_pkg::OP_REORDER, 6'd0, 6'd20, etsl_pkg::DIR_UP);
      send_request(OP_NONE, 6'd63, 6'd63, DIR_NONE);
      for (n = 0; n < 16; n++) begin
         send_request(etsl_pkg::OP_APPEND, fill_floors[n], 6'd31, etsl_pkg::DIR_HERE);
      end
      send_request(etsl_pkg::OP_APPEND, 6'd9, 6'd31, etsl_pkg::DIR_UP);
      send_request(etsl_pkg::OP_REORDER, 6'd0, 6'd31, etsl_pkg::DIR_UP);
      send_request(etsl_pkg::OP_REORDER, 6'd0, 6'd31, etsl_pkg::DIR_DOWN);
      send_request(etsl_pkg::OP_REORDER, 6'd0, 6'd63, etsl_pkg::DIR_HERE);
      send_request(etsl_pkg::OP_REORDER, 6'd0, 6'd0, DIR_NONE);
      send_request(etsl_pkg::OP_REMOVE, 6'd0, 6'd63, etsl_pkg::DIR_DOWN);
      wait_drained();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               rsp_stall_pct = 47;
            end
            1: begin
               send_idle_pct = 47;
               rsp_stall_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         filling = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % MODE_SPAN == 0 && n != 0) begin
               filling = 1'($urandom_range(1));
            end
            r = $urandom_range(99);
            if (filling) begin
               op = (r < 50) ? etsl_pkg::OP_APPEND : (r < 68) ? etsl_pkg::OP_REMOVE :
                    (r < 95) ? etsl_pkg::OP_REORDER : OP_NONE;
            end else begin
               op = (r < 18) ? etsl_pkg::OP_APPEND : (r < 63) ? etsl_pkg::OP_REMOVE :
                    (r < 95) ? etsl_pkg::OP_REORDER : OP_NONE;
            end
            r = $urandom_range(9);
            dir = (r < 4) ? etsl_pkg::DIR_UP : (r < 8) ? etsl_pkg::DIR_DOWN :
                  (r == 8) ? etsl_pkg::DIR_HERE : DIR_NONE;
            send_request(op, pick_floor(), pick_floor(), dir);
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d appends, %0d head removals, %0d reorders, %0d no-op transactions",
               op_seen[etsl_pkg::OP_APPEND], op_seen[etsl_pkg::OP_REMOVE],
               op_seen[etsl_pkg::OP_REORDER], op_seen[OP_NONE]);
      $display("%0d responses checked, %0d rejected, across three idling profiles",
               checked, rejects);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
